// ----- design/streaming_kth_largest_top_assert.svh -----
// Assertion helpers shared by the streaming k-th largest block.
`ifndef STREAMING_KTH_LARGEST_TOP_ASSERT_SVH
`define STREAMING_KTH_LARGEST_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SKT_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/skt_pkg.sv -----
package skt_pkg;

   localparam int VALUE_W = 32;
   localparam int RANK_W  = 7;

   typedef logic signed [VALUE_W-1:0] value_type;

   // Link from one cell to its right neighbor
   typedef struct packed {
      logic      keep;   // this cell holds a value >= the incoming one
      value_type value;  // this cell's stored value
   } link_type;

endpackage

// ----- design/skt_cell.sv -----
module skt_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  logic               occupied,
   input  skt_pkg::value_type ins_value,
   input  skt_pkg::link_type  left_link,
   output skt_pkg::link_type  right_link
);

   skt_pkg::value_type value_ff;
   skt_pkg::value_type value_in;
   logic               keep;

   // Entry stays when it is valid and not smaller than the new value
   assign keep = occupied && (value_ff >= ins_value);

   // Keep own value, take the new one at the insertion point, else shift right
   always_comb begin
      if (keep) begin
         value_in = value_ff;
      end else if (left_link.keep) begin
         value_in = ins_value;
      end else begin
         value_in = left_link.value;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= value_in;
      end
   end

   assign right_link = '{keep: keep, value: value_ff};

endmodule

// ----- design/streaming_kth_largest_top.sv -----
// Streaming k-th largest: takes signed 32-bit values one per beat on req_, the
// beat with req_tlast closing a set, and returns one rsp_ beat per set holding the
// k-th largest value of that set (the smallest held value when the set was short,
// with rsp_tuser set). k comes from csr_data, clamped to 1..MAX_RANK; a new k takes
// effect from the next beat, and lowering it in the middle of a set drops the
// smallest held values. Values sit in a sorted row of MAX_RANK insertion cells that
// all update together, so beats without tlast are taken every cycle. After a beat
// with tlast, req_tready is low while the result is read out of the row through a
// two-level registered mux; req_tready also stays low if that read-out stage still
// waits on a stalled rsp_ output register.
`include "streaming_kth_largest_top_assert.svh"

module streaming_kth_largest_top #(
   parameter int MAX_RANK = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // slave side: tdata = value[31:0]
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [skt_pkg::VALUE_W-1:0] req_tdata,
   input  logic                        req_tlast,
   // master side: tdata = kth_value[31:0]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [skt_pkg::VALUE_W-1:0] rsp_tdata,
   // tuser = fewer_than_k[0]
   output logic                        rsp_tuser,
   // rank register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [skt_pkg::RANK_W-1:0]  csr_data
);

   localparam int IDX_W  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int CNT_W  = $clog2(MAX_RANK + 1);
   localparam int LOW_W  = (IDX_W + 1) / 2;
   localparam int HIGH_W = IDX_W - LOW_W;
   localparam int GROUPS = 1 << HIGH_W;
   localparam int GSIZE  = 1 << LOW_W;
   localparam int HSEL_W = (HIGH_W > 0) ? HIGH_W : 1;

   logic               req_accept;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W:0]     cnt_inc;
   logic [CNT_W-1:0]   cnt_new;
   logic [CNT_W-1:0]   idx_full;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               fewer_ff;
   logic               sel_valid_ff;
   logic               grp_valid_ff, grp_valid_in;
   logic [HSEL_W-1:0]  hsel;
   logic               out_free;
   logic               rsp_valid_ff;
   skt_pkg::value_type rsp_data_ff;
   logic               rsp_user_ff;
   logic [31:0]        rank_wide;

   skt_pkg::value_type ins_value;
   skt_pkg::link_type  link [MAX_RANK+1];
   skt_pkg::value_type padded [GROUPS][GSIZE];
   skt_pkg::value_type grp_ff [GROUPS];

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = !sel_valid_ff && !grp_valid_ff;
   assign csr_ready  = 1'b1;
   assign ins_value  = skt_pkg::value_type'(req_tdata);

   // Rank register, clamped on write
   always_comb begin
      rank_wide = 32'(csr_data);
      if (rank_wide == 32'd0) begin
         k_in = CNT_W'(1);
      end else if (rank_wide > 32'(MAX_RANK)) begin
         k_in = CNT_W'(MAX_RANK);
      end else begin
         k_in = CNT_W'(rank_wide);
      end
   end

   // Fill count after this insertion, trimmed to k
   assign cnt_inc  = {1'b0, cnt_ff} + (CNT_W+1)'(1);
   assign cnt_new  = (cnt_inc > {1'b0, k_ff}) ? k_ff : cnt_inc[CNT_W-1:0];
   assign idx_full = cnt_new - CNT_W'(1);

   always_comb begin
      cnt_in = cnt_ff;
      if (req_accept) begin
         cnt_in = req_tlast ? '0 : cnt_new;
      end
   end

   // Sorted insertion row, largest value in cell 0
   assign link[0] = '{keep: 1'b1, value: '0};

   for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
      skt_cell u_cell (
         .clock      (clock),
         .shift_en   (req_accept),
         .occupied   (cnt_ff > CNT_W'(i)),
         .ins_value  (ins_value),
         .left_link  (link[i]),
         .right_link (link[i+1])
      );
   end

   // Row values arranged for the two-level read-out, padded with zeros
   for (genvar p = 0; p < GROUPS * GSIZE; p++) begin : g_pad
      if (p < MAX_RANK) begin : g_real
         assign padded[p / GSIZE][p % GSIZE] = link[p+1].value;
      end else begin : g_fill
         assign padded[p / GSIZE][p % GSIZE] = '0;
      end
   end

   if (HIGH_W > 0) begin : g_hsel
      assign hsel = rd_idx_ff[IDX_W-1:LOW_W];
   end else begin : g_hsel_one
      assign hsel = '0;
   end

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign grp_valid_in = sel_valid_ff || (grp_valid_ff && !out_free);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= CNT_W'(1);
         cnt_ff       <= '0;
         sel_valid_ff <= 1'b0;
         grp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            k_ff <= k_in;
         end
         cnt_ff       <= cnt_in;
         sel_valid_ff <= req_accept && req_tlast;
         grp_valid_ff <= grp_valid_in;
         if (grp_valid_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Read-out payload
   always_ff @(posedge clock) begin
      if (req_accept && req_tlast) begin
         rd_idx_ff <= idx_full[IDX_W-1:0];
         fewer_ff  <= cnt_new < k_ff;
      end
      if (sel_valid_ff) begin
         for (int g = 0; g < GROUPS; g++) begin
            grp_ff[g] <= padded[g][rd_idx_ff[LOW_W-1:0]];
         end
      end
      if (grp_valid_ff && out_free) begin
         rsp_data_ff <= grp_ff[hsel];
         rsp_user_ff <= fewer_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Checks
   `SKT_ASSERT_NEXT(a_count_clears, clock, reset, req_accept && req_tlast, cnt_ff == '0, "count not cleared after last beat")
   `SKT_ASSERT_NEXT(a_sel_to_grp, clock, reset, sel_valid_ff, grp_valid_ff && !req_tready, "read-out did not advance")
   `SKT_ASSERT_NEXT(a_grp_held, clock, reset, grp_valid_ff && rsp_valid_ff && !rsp_tready, grp_valid_ff, "result lost under stall")
   `SKT_ASSERT_HOLDS(a_count_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_RANK), "fill count past row length")

endmodule
